[rtl/ipfb_pkg.sv]
// Shared constants and types for the in-place five-point blur.
package ipfb_pkg;

	// Frame geometry
	localparam int WIDTH  = 800;
	localparam int HEIGHT = 600;
	localparam int COL_W  = $clog2(WIDTH);
	localparam int ROW_W  = $clog2(HEIGHT);

	// One RGB pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// Per-request position and handling, decided when the request is taken
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             emit;
		logic             filter;
		logic             frame_end;
	} pos_t;

endpackage

[rtl/ipfb_raster_ctr.sv]
// Raster position counter and per-request classification.
module ipfb_raster_ctr (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	output ipfb_pkg::pos_t pos
);
	import ipfb_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             first_done_q;
	logic             last_col;

	assign last_col = (col_q == COL_W'(WIDTH - 1));

	// Advance column and row on every taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			first_done_q <= 1'b0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				if (row_q == ROW_W'(HEIGHT - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
				if (row_q == '0) begin
					first_done_q <= 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Classify the current position
	always_comb begin
		pos.col       = col_q;
		pos.emit      = (row_q != '0) || first_done_q;
		pos.filter    = (row_q != '0) && (row_q != ROW_W'(1));
		pos.frame_end = (row_q == '0) && last_col;
	end

endmodule

[rtl/ipfb_line_buf.sv]
// Original and filtered row buffers with registered reads.
module ipfb_line_buf (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [ipfb_pkg::COL_W-1:0]  col,
	input  ipfb_pkg::pixel_t            orig_wr_data,
	input  logic                        filt_wr_en,
	input  logic [ipfb_pkg::COL_W-1:0]  filt_wr_col,
	input  ipfb_pkg::pixel_t            filt_wr_data,
	output ipfb_pkg::pixel_t            above_q,
	output ipfb_pkg::pixel_t            right_q,
	output ipfb_pkg::pixel_t            upper_q
);
	import ipfb_pkg::*;

	pixel_t           orig_mem [WIDTH];
	pixel_t           filt_mem [WIDTH];
	logic [COL_W-1:0] right_col;

	// Right neighbor follows the flat index: last column wraps to column zero
	assign right_col = (col == COL_W'(WIDTH - 1)) ? '0 : col + 1'b1;

	// Original row: read old value and the right neighbor, then store the new pixel
	always_ff @(posedge clk) begin
		if (rd_en) begin
			above_q       <= orig_mem[col];
			right_q       <= orig_mem[right_col];
			orig_mem[col] <= orig_wr_data;
		end
	end

	// Filtered row: read the pixel two rows up, store fresh results
	always_ff @(posedge clk) begin
		if (rd_en) begin
			upper_q <= filt_mem[col];
		end
		if (filt_wr_en) begin
			filt_mem[filt_wr_col] <= filt_wr_data;
		end
	end

endmodule

[rtl/ipfb_avg.sv]
// Per-channel truncated average of five pixels.
module ipfb_avg (
	input  ipfb_pkg::pixel_t a,
	input  ipfb_pkg::pixel_t b,
	input  ipfb_pkg::pixel_t c,
	input  ipfb_pkg::pixel_t d,
	input  ipfb_pkg::pixel_t e,
	output ipfb_pkg::pixel_t avg
);
	import ipfb_pkg::*;

	// Divide an 11-bit sum by five: multiply by 13108 / 2^16, exact below 1280
	function automatic logic [7:0] div5(input logic [10:0] s);
		logic [24:0] p;
		p = {14'd0, s} * 25'd13108;
		return p[23:16];
	endfunction

	function automatic logic [10:0] sum5(input logic [7:0] v0, input logic [7:0] v1,
		input logic [7:0] v2, input logic [7:0] v3, input logic [7:0] v4);
		return {3'd0, v0} + {3'd0, v1} + {3'd0, v2} + {3'd0, v3} + {3'd0, v4};
	endfunction

	// Average each channel
	always_comb begin
		avg.red   = div5(sum5(a.red,   b.red,   c.red,   d.red,   e.red));
		avg.green = div5(sum5(a.green, b.green, c.green, d.green, e.green));
		avg.blue  = div5(sum5(a.blue,  b.blue,  c.blue,  d.blue,  e.blue));
	end

endmodule

[rtl/in_place_five_point_blur.sv]
// Top level: in-place five-point cross blur over a raster pixel stream.
// A request waits in the input stage, then loads the result register, which holds the
// pixel one row up.
// Throughput: one pixel per clock when not stalled; the last filtered pixel loop sets it.
// Reset: clears the raster position, the first-row flag, the last filtered pixel and the
// valid flags; the row buffers keep their contents and are always written before being read.
module in_place_five_point_blur (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       out_frame_end
);
	import ipfb_pkg::*;

	pos_t   pos;
	pixel_t in_pix;
	logic   in_fire;

	logic   valid_s1;
	pos_t   info_s1;
	pixel_t pix_s1;
	logic   s1_go;
	logic   s1_load_out;

	pixel_t above_q;
	pixel_t right_q;
	pixel_t upper_q;
	pixel_t last_q;
	pixel_t blur;
	pixel_t result;

	logic   out_valid_q;
	pixel_t out_pix_q;
	logic   out_end_q;

	assign in_pix  = '{blue: in_blue, green: in_green, red: in_red};
	assign in_fire = in_valid && in_ready;

	// Drain the stage when its result has room or it produces nothing
	assign s1_go       = valid_s1 && (!info_s1.emit || !out_valid_q || out_ready);
	assign s1_load_out = s1_go && info_s1.emit;
	assign in_ready    = !valid_s1 || s1_go;

	ipfb_raster_ctr u_ctr (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_fire),
		.pos     (pos)
	);

	ipfb_line_buf u_buf (
		.clk          (clk),
		.rd_en        (in_fire),
		.col          (pos.col),
		.orig_wr_data (in_pix),
		.filt_wr_en   (s1_load_out),
		.filt_wr_col  (info_s1.col),
		.filt_wr_data (result),
		.above_q      (above_q),
		.right_q      (right_q),
		.upper_q      (upper_q)
	);

	ipfb_avg u_avg (
		.a   (above_q),
		.b   (upper_q),
		.c   (pix_s1),
		.d   (last_q),
		.e   (right_q),
		.avg (blur)
	);

	assign result = info_s1.filter ? blur : above_q;

	// Hold the request in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1 <= pos;
			pix_s1  <= in_pix;
		end
	end

	// Track the left neighbor: the most recent result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (s1_load_out) begin
			last_q <= result;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load_out) begin
			out_pix_q <= result;
			out_end_q <= info_s1.frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_red       = out_pix_q.red;
	assign out_green     = out_pix_q.green;
	assign out_blue      = out_pix_q.blue;
	assign out_frame_end = out_end_q;

	// A blocked result stage must back-pressure the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && info_s1.emit && out_valid_q && !out_ready) |-> !in_ready)
		else $error("request taken while the input stage is blocked");

	// A result moved out of the stage shows up as valid next cycle
	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_load_out |=> out_valid_q)
		else $error("loaded result not presented");

	// Column wraps to zero after the last column
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && pos.col == COL_W'(WIDTH - 1)) |=> (pos.col == '0))
		else $error("column did not wrap");

	// A frame end only marks a pass-through pixel of the first input row
	a_frame_end_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && info_s1.frame_end) |-> !info_s1.filter)
		else $error("frame end on a filtered pixel");

endmodule
